### sv/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg : shared definitions for the double-ended queue
// Field widths, operation and status codes, and the control group that
// travels from the pointer controller to the result stage.
// ----------------------------------------------------------------------------
package dq_pkg;

   // Fixed field widths
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;

   // Default capacity in entries
   localparam int DEPTH_DEF = 16;

   // Operation codes
   localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 2'd0;
   localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 2'd1;
   localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 2'd2;
   localparam logic [FUNC_W-1:0] FN_POP_REAR   = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Control group for one result
   typedef struct packed {
      logic                valid;   // result strobe
      logic                pop_ok;  // popped word comes from the RAM
      logic [STATUS_W-1:0] status;
   } rsp_ctl_type;

endpackage

### sv/dq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram : generic single-port RAM
// One write and one read per cycle through the single address; read data registered.
// ----------------------------------------------------------------------------
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl : head and count controller
// Keeps the ring's head index and entry count, decides the status of each
// transaction and drives the RAM address for the one entry it touches.
// ----------------------------------------------------------------------------
module dq_ctrl
   import dq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [FUNC_W-1:0]          func,
   input  logic signed [DATA_W-1:0]   push_value,
   output logic                       mem_wr_en,
   output logic                       mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]   mem_addr,
   output logic [DATA_W-1:0]          mem_wr_data,
   output rsp_ctl_type                rsp_ctl,
   output logic [$clog2(DEPTH+1)-1:0] occupancy
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_ctl_type      rsp_ctl_ff, rsp_ctl_in;

   logic             is_push;
   logic             full;
   logic             empty;
   logic [CNT_W-1:0] rear_off;
   logic [SUM_W-1:0] rear_sum;
   logic [SUM_W-1:0] rear_wrap;
   logic [IDX_W-1:0] rear_slot;
   logic [IDX_W-1:0] head_dec;
   logic [IDX_W-1:0] head_inc;

   // Queue state flags
   assign is_push = (func == FN_PUSH_FRONT) || (func == FN_PUSH_REAR);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);

   // Rear slot: one past the rear for a push, the rear itself for a pop
   assign rear_off  = is_push ? count_ff : count_ff - CNT_W'(1);
   assign rear_sum  = SUM_W'(head_ff) + SUM_W'(rear_off);
   assign rear_wrap = (rear_sum >= SUM_W'(DEPTH)) ? rear_sum - SUM_W'(DEPTH) : rear_sum;
   assign rear_slot = rear_wrap[IDX_W-1:0];

   // Head stepped back and forward round the ring
   assign head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);

   assign mem_wr_data = push_value;

   // Operation decode
   always_comb begin
      head_in           = head_ff;
      count_in          = count_ff;
      mem_wr_en         = 1'b0;
      mem_rd_en         = 1'b0;
      mem_addr          = rear_slot;
      rsp_ctl_in.valid  = accept;
      rsp_ctl_in.pop_ok = 1'b0;
      rsp_ctl_in.status = ST_OK;
      if (accept) begin
         if (is_push && full) begin
            rsp_ctl_in.status = ST_FULL;
         end else if (!is_push && empty) begin
            rsp_ctl_in.status = ST_EMPTY;
         end else begin
            unique case (func)
               FN_PUSH_FRONT: begin
                  head_in   = head_dec;
                  count_in  = count_ff + CNT_W'(1);
                  mem_addr  = head_dec;
                  mem_wr_en = 1'b1;
               end
               FN_PUSH_REAR: begin
                  count_in  = count_ff + CNT_W'(1);
                  mem_wr_en = 1'b1;
               end
               FN_POP_FRONT: begin
                  head_in           = head_inc;
                  count_in          = count_ff - CNT_W'(1);
                  mem_addr          = head_ff;
                  mem_rd_en         = 1'b1;
                  rsp_ctl_in.pop_ok = 1'b1;
               end
               FN_POP_REAR: begin
                  count_in          = count_ff - CNT_W'(1);
                  mem_rd_en         = 1'b1;
                  rsp_ctl_in.pop_ok = 1'b1;
               end
               default: begin
                  head_in = head_ff;
               end
            endcase
         end
      end
   end

   // State and result control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         rsp_ctl_ff <= '0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         rsp_ctl_ff <= rsp_ctl_in;
      end
   end

   assign rsp_ctl   = rsp_ctl_ff;
   assign occupancy = count_ff;

endmodule

### sv/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue : ring-buffer deque of signed 32-bit words
// The result strobe comes in the cycle after the transaction is taken.
// Throughput: one transaction per cycle; busy stays low, since each transaction
// touches one RAM entry through the single port and head and count update as it is taken.
// The receiver cannot stall; every result is on the ports for one cycle.
// Reset clears head and count (queue empty); RAM contents are left as they are.
// ----------------------------------------------------------------------------
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [FUNC_W-1:0]          req_func,
   input  logic signed [DATA_W-1:0]   req_push_value,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0]   rsp_popped_value,
   output logic [$clog2(DEPTH+1)-1:0] rsp_occupancy
);

   localparam int IDX_W = $clog2(DEPTH);

   logic             accept;
   logic             mem_wr_en;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic [DATA_W-1:0] mem_rd_data;
   rsp_ctl_type      rsp_ctl;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   dq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_func),
      .push_value  (req_push_value),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .rsp_ctl     (rsp_ctl),
      .occupancy   (rsp_occupancy)
   );

   dq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // Result stage: popped word only on a successful pop
   assign rsp_strobe       = rsp_ctl.valid;
   assign rsp_status       = rsp_ctl.status;
   assign rsp_popped_value = rsp_ctl.pop_ok ? $signed(mem_rd_data) : '0;

endmodule

### tb/sv/double_ended_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test : self-checking regression for the deque
// Drives push and pop transactions at both ends and predicts every result
// from a local ring model (head slot plus entry count). Each result is
// compared field by field with the oldest prediction. Directed cases come
// first, then biased random walks that hit full and empty often, then back to back.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
   import dq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH_DEF);
   localparam int OCC_W = $clog2(DEPTH_DEF + 1);
   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic signed [DATA_W-1:0]   value;
      logic [OCC_W-1:0]           occupancy;
   } deque_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [FUNC_W-1:0]          req_func = FN_POP_FRONT;
   logic signed [DATA_W-1:0]   req_push_value = '0;
   logic                       rsp_strobe;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0]   rsp_popped_value;
   logic [OCC_W-1:0]           rsp_occupancy;

   // Local copy of the ring
   logic signed [DATA_W-1:0]   ring_words [DEPTH_DEF];
   logic [IDX_W-1:0]           front_slot = '0;
   logic [OCC_W-1:0]           word_count = '0;

   deque_result_type           pending_results [$];
   int                         mismatch_count = 0;

   double_ended_queue u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_push_value   (req_push_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_occupancy    (rsp_occupancy)
   );

   always #5 clock = ~clock;

   // Run limit
   initial begin
      #5ms;
      $display("double_ended_queue regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Apply one operation to the local ring and return the expected result
   function automatic deque_result_type deque_apply(input logic [FUNC_W-1:0] fn,
                                                    input logic signed [DATA_W-1:0] word);
      deque_result_type r;
      logic [IDX_W-1:0] slot;
      r.status = ST_OK;
      r.value  = '0;
      if (fn == FN_PUSH_FRONT || fn == FN_PUSH_REAR) begin
         if (word_count == DEPTH_DEF) begin
            r.status = ST_FULL;
         end else if (fn == FN_PUSH_FRONT) begin
            front_slot = front_slot - 1'b1;   // wraps below slot zero
            ring_words[front_slot] = word;
            word_count++;
         end else begin
            slot = IDX_W'(front_slot + word_count);
            ring_words[slot] = word;
            word_count++;
         end
      end else begin
         if (word_count == 0) begin
            r.status = ST_EMPTY;
         end else if (fn == FN_POP_FRONT) begin
            r.value = ring_words[front_slot];
            front_slot = front_slot + 1'b1;
            word_count--;
         end else begin
            slot = IDX_W'(front_slot + word_count - OCC_W'(1));
            r.value = ring_words[slot];
            word_count--;
         end
      end
      r.occupancy = word_count;
      return r;
   endfunction

   // Result check then prediction for the transaction taken at this edge
   always @(posedge clock) begin
      deque_result_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with no transaction outstanding");
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_popped_value !== want.value)
                  report_mismatch($sformatf("popped value %0h, expected %0h",
                                            rsp_popped_value, want.value));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy %0d, expected %0d",
                                            rsp_occupancy, want.occupancy));
            end
         end else if (rsp_strobe !== 1'b0) begin
            report_mismatch("result strobe unknown");
         end
         if (start && busy === 1'b0)
            pending_results.push_back(deque_apply(req_func, req_push_value));
      end
   end

   // Present one transaction and hold it until the block takes it
   task automatic send_op(input logic [FUNC_W-1:0] fn,
                          input logic signed [DATA_W-1:0] word);
      start          <= 1'b1;
      req_func       <= fn;
      req_push_value <= word;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic idle_for(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained(input int limit);
      int n;
      n = 0;
      start <= 1'b0;
      do begin
         @(posedge clock);
         n++;
      end while (pending_results.size() != 0 && n < limit);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [FUNC_W-1:0] pick_op(input int push_pct);
      if ($urandom_range(0, 99) < push_pct)
         return $urandom_range(0, 1) ? FN_PUSH_REAR : FN_PUSH_FRONT;
      return $urandom_range(0, 1) ? FN_POP_REAR : FN_POP_FRONT;
   endfunction

   // Pops on an empty queue are rejected from either end
   task automatic test_empty_rejects();
      send_op(FN_POP_FRONT, 32'sh7fff_ffff);
      send_op(FN_POP_REAR, 32'sh8000_0000);
   endtask

   // Fill from both ends across the wrap, reject pushes when full, pop both ends
   task automatic test_fill_and_full();
      for (int i = 0; i < DEPTH_DEF; i++) begin
         case (i % 4)
            0: send_op(FN_PUSH_FRONT, -1);
            1: send_op(FN_PUSH_REAR, 32'sh7fff_ffff);
            2: send_op(FN_PUSH_FRONT, 32'sh8000_0000);
            default: send_op(FN_PUSH_REAR, $urandom);
         endcase
      end
      send_op(FN_PUSH_FRONT, 32'sh1234_5678);
      send_op(FN_PUSH_REAR, 32'sh0);
      send_op(FN_POP_FRONT, 32'sh0);
      send_op(FN_POP_REAR, -1);
   endtask

   // Biased random walks between empty and full, with sender gaps
   task automatic test_random_walk(input int total);
      int sent, run_len, push_pct;
      bit gaps_on, paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < total) begin
         run_len  = $urandom_range(20, 120);
         case ($urandom_range(0, 3))
            0:       push_pct = 80;
            1:       push_pct = 20;
            2:       push_pct = 55;
            default: push_pct = 45;
         endcase
         gaps_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < run_len && sent < total; i++) begin
            if (gaps_on && $urandom_range(0, 5) == 0)
               idle_for($urandom_range(1, 16));
            send_op(pick_op(push_pct), pick_word());
            sent++;
         end
         // let the queue settle completely once, midway through
         if (!paused && sent >= total / 2) begin
            wait_drained(1000);
            paused = 1'b1;
         end
      end
   endtask

   // Closing stretch: one transaction every cycle
   task automatic test_back_to_back(input int total);
      int push_pct;
      push_pct = 50;
      for (int i = 0; i < total; i++) begin
         if (i % 40 == 0)
            push_pct = $urandom_range(15, 85);
         send_op(pick_op(push_pct), pick_word());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_rejects();
      test_fill_and_full();
      test_random_walk(1330);
      test_back_to_back(300);
      wait_drained(1000);
      idle_for(5);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      if (mismatch_count == 0)
         $display("double_ended_queue regression: pass");
      else
         $display("double_ended_queue regression: fail");
      $finish;
   end

endmodule

### double_ended_queue.f
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_ctrl.sv
sv/double_ended_queue.sv
tb/sv/double_ended_queue_test.sv
